/* design/stereo_fir_crosstalk_canceller_macros.svh */
// Assertion macros for the stereo FIR crosstalk canceller.
`ifndef STEREO_FIR_CROSSTALK_CANCELLER_MACROS_SVH
`define STEREO_FIR_CROSSTALK_CANCELLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sfcc_pkg.sv */
// Shared constants and controller/datapath interface types.
package sfcc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int KIND_W     = 2;
  localparam int TAP_IDX_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int TAPS_CFG_W = 7;
  localparam int ALPHA_W    = 14;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int ACC_W      = 48;
  localparam int XP_W       = ACC_W + ALPHA_W + 1;
  localparam int MIN_TAPS   = 8;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_L = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD_R = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS     = 1'b1;

  localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 7'd64;

  typedef struct packed {
    logic sample;
    logic load_l;
    logic load_r;
    logic issue;
    logic xt;
    logic fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

/* design/sfcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sfcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sfcc_ctrl.sv */
// Sequencer: input handshake, tap walk and crosstalk/output steps.
module sfcc_ctrl #(
  parameter int MAX_TAPS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sfcc_pkg::KIND_W-1:0]       kind_i,
  input  logic [$clog2(MAX_TAPS+1)-1:0]     taps_i,
  input  sfcc_pkg::ctrl_sts_t               sts_i,
  output sfcc_pkg::ctrl_cmd_t               cmd_o,
  output logic [$clog2(MAX_TAPS)-1:0]       tap_o
);

  import sfcc_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);
  localparam int TW = $clog2(MAX_TAPS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RUN   = 6'b000010,
    ST_WAIT1 = 6'b000100,
    ST_WAIT2 = 6'b001000,
    ST_MULX  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] tap_q, tap_d;

  always_comb begin
    state_d    = state_q;
    tap_d      = tap_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_l = (kind_i == KIND_LOAD_L);
          cmd_o.load_r = (kind_i == KIND_LOAD_R);
          if (kind_i == KIND_SAMPLE) begin
            cmd_o.sample = 1'b1;
            tap_d        = '0;
            state_d      = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (TW'(tap_q) == taps_i - TW'(1)) begin
          state_d = ST_WAIT1;
        end else begin
          tap_d = tap_q + AW'(1);
        end
      end
      ST_WAIT1: begin
        state_d = ST_WAIT2;
      end
      ST_WAIT2: begin
        state_d = ST_MULX;
      end
      ST_MULX: begin
        cmd_o.xt = 1'b1;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

/* design/sfcc_datapath.sv */
// Datapath: config registers, history and kernel RAMs, MAC pair, crosstalk and output.
module sfcc_datapath #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sfcc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sfcc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 frame_start_i,
  input  logic [sfcc_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input  logic signed [sfcc_pkg::SAMPLE_W-1:0] value_i,
  input  sfcc_pkg::ctrl_cmd_t                  cmd_i,
  input  logic [$clog2(MAX_TAPS)-1:0]          tap_i,
  output sfcc_pkg::ctrl_sts_t                  sts_o,
  output logic [$clog2(MAX_TAPS+1)-1:0]        taps_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [sfcc_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [sfcc_pkg::SAMPLE_W-1:0] right_out_o,
  output logic                                 clipped_o
);

  import sfcc_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int Q_W = 64 - 30;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh4000_0000_0000;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;
  localparam logic signed [63:0]      RND_HALF = 64'sd536870912;
  localparam logic signed [Q_W-1:0]   Q_HI = 34'sd32767;
  localparam logic signed [Q_W-1:0]   Q_LO = -34'sd32768;

  // Configuration
  logic [ALPHA_W-1:0]    alpha_q;
  logic [TAPS_CFG_W-1:0] taps_raw_q;
  logic [16:0]           str_c;
  logic [16:0]           str_x3;
  logic [32:0]           alpha_prod;

  always_comb begin
    str_c      = (cfg_wdata_i > 16'd32768) ? 17'd32768 : {1'b0, cfg_wdata_i};
    str_x3     = 17'(str_c * 17'd3) + 17'd5;
    // divide by ten: reciprocal multiply, exact below 2^18
    alpha_prod = 33'(str_x3) * 33'd52429;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= '0;
      taps_raw_q <= TAPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STRENGTH: alpha_q    <= alpha_prod[32:19];
        REG_TAPS:     taps_raw_q <= cfg_wdata_i[TAPS_CFG_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    if (32'(taps_raw_q) < MIN_TAPS) begin
      taps_o = TW'(MIN_TAPS);
    end else if (32'(taps_raw_q) > MAX_TAPS) begin
      taps_o = TW'(MAX_TAPS);
    end else begin
      taps_o = TW'(taps_raw_q);
    end
  end

  // History ring and fill count
  logic [AW-1:0] np_q, np_next, rp_q;
  logic [TW-1:0] fill_q;

  assign np_next = (np_q == AW'(MAX_TAPS - 1)) ? '0 : np_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else if (cmd_i.sample) begin
      np_q <= np_next;
      rp_q <= np_next;
      if (frame_start_i) begin
        fill_q <= TW'(1);
      end else if (fill_q != TW'(MAX_TAPS)) begin
        fill_q <= fill_q + TW'(1);
      end
    end else if (cmd_i.issue) begin
      rp_q <= (rp_q == '0) ? AW'(MAX_TAPS - 1) : rp_q - AW'(1);
    end
  end

  logic                       idx_ok;
  logic [SAMPLE_W-1:0]        hist_rd, kl_rd, kr_rd;

  assign idx_ok = 32'(tap_index_i) < MAX_TAPS;

  sfcc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sample),
    .waddr_i (np_next),
    .wdata_i (value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (rp_q),
    .rdata_o (hist_rd)
  );

  sfcc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_kern_l_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_l && idx_ok),
    .waddr_i (AW'(tap_index_i)),
    .wdata_i (value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (tap_i),
    .rdata_o (kl_rd)
  );

  sfcc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_kern_r_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_r && idx_ok),
    .waddr_i (AW'(tap_index_i)),
    .wdata_i (value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (tap_i),
    .rdata_o (kr_rd)
  );

  // MAC pipeline: read, multiply, accumulate with clamp
  logic                       rd_v_q, mask_q, prod_v_q;
  logic signed [SAMPLE_W-1:0] hist_s, kl_s, kr_s;
  logic signed [PROD_W-1:0]   prod_l_q, prod_r_q;
  logic signed [ACC_W-1:0]    acc_l_q, acc_r_q, sum_l, sum_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      mask_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.issue;
      mask_q   <= TW'(tap_i) < fill_q;
      prod_v_q <= rd_v_q;
    end
  end

  always_comb begin
    hist_s = mask_q ? signed'(hist_rd) : '0;
    kl_s   = signed'(kl_rd);
    kr_s   = signed'(kr_rd);
    sum_l  = acc_l_q + ACC_W'(prod_l_q);
    sum_r  = acc_r_q + ACC_W'(prod_r_q);
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_l_q <= hist_s * kl_s;
      prod_r_q <= hist_s * kr_s;
    end
    if (cmd_i.sample) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (prod_v_q) begin
      acc_l_q <= (sum_l > ACC_MAX) ? ACC_MAX : ((sum_l < ACC_MIN) ? ACC_MIN : sum_l);
      acc_r_q <= (sum_r > ACC_MAX) ? ACC_MAX : ((sum_r < ACC_MIN) ? ACC_MIN : sum_r);
    end
  end

  // Crosstalk products
  logic signed [ALPHA_W:0]  alpha_s;
  logic signed [XP_W-1:0]   xl_q, xr_q;

  assign alpha_s = signed'({1'b0, alpha_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.xt) begin
      xl_q <= acc_r_q * alpha_s;
      xr_q <= acc_l_q * alpha_s;
    end
  end

  // Round half up to Q1.15 and saturate
  logic signed [63:0]       vl, vr, tl, tr;
  logic signed [Q_W-1:0]    ql, qr;
  logic signed [SAMPLE_W-1:0] sl, sr;
  logic                     cl, cr;

  always_comb begin
    vl = (64'(acc_l_q) <<< 15) - 64'(xl_q);
    vr = (64'(acc_r_q) <<< 15) - 64'(xr_q);
    tl = vl + RND_HALF;
    tr = vr + RND_HALF;
    ql = signed'(tl[63:30]);
    qr = signed'(tr[63:30]);
    cl = (ql > Q_HI) || (ql < Q_LO);
    cr = (qr > Q_HI) || (qr < Q_LO);
    sl = (ql > Q_HI) ? 16'sh7fff : ((ql < Q_LO) ? 16'sh8000 : ql[SAMPLE_W-1:0]);
    sr = (qr > Q_HI) ? 16'sh7fff : ((qr < Q_LO) ? 16'sh8000 : qr[SAMPLE_W-1:0]);
  end

  // Output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] left_q, right_q;
  logic                       clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      left_q  <= sl;
      right_q <= sr;
      clip_q  <= cl || cr;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign left_out_o     = left_q;
  assign right_out_o    = right_q;
  assign clipped_o      = clip_q;

endmodule

/* design/stereo_fir_crosstalk_canceller.sv */
// Top level of the stereo FIR crosstalk canceller.
`include "stereo_fir_crosstalk_canceller_macros.svh"

// Each audio beat is filtered through the left and right kernels by one
// pair of 16x16 MACs that walk the taps one per cycle, then crosstalk is
// cancelled and both channels are rounded and saturated to Q1.15. An audio
// beat is accepted, walks its taps, drains the read/multiply pipeline
// through ST_WAIT1 and ST_WAIT2, runs the crosstalk multiply and loads
// the output register, which may stall there while an earlier result is
// still waiting. Coefficient and unused beats are taken in the idle state
// and give no result. History clears at frame start through a fill
// count, so no clearing pass is needed. Unwritten kernel taps read as
// undefined: load every tap in use before streaming audio.
module stereo_fir_crosstalk_canceller #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sfcc_pkg::KIND_W-1:0]          kind_i,
  input  logic                                 frame_start_i,
  input  logic [sfcc_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input  logic signed [sfcc_pkg::SAMPLE_W-1:0] value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [sfcc_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [sfcc_pkg::SAMPLE_W-1:0] right_out_o,
  output logic                                 clipped_o,
  input  logic                                 cfg_we_i,
  input  logic [sfcc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sfcc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  import sfcc_pkg::*;

  ctrl_cmd_t                     cmd;
  ctrl_sts_t                     sts;
  logic [$clog2(MAX_TAPS)-1:0]   tap;
  logic [$clog2(MAX_TAPS+1)-1:0] taps;
  logic                          sample_beat;

  assign sample_beat = in_valid_i && in_ready_o && (kind_i == KIND_SAMPLE);

  sfcc_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .taps_i     (taps),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .tap_o      (tap)
  );

  sfcc_datapath #(.MAX_TAPS(MAX_TAPS)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .frame_start_i (frame_start_i),
    .tap_index_i   (tap_index_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .tap_i         (tap),
    .sts_o         (sts),
    .taps_o        (taps),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .clipped_o     (clipped_o)
  );

  `SFCC_ASSERT_NOW(a_no_ready_while_busy, cmd.issue, !in_ready_o, "ready during tap walk")
  `SFCC_ASSERT_NOW(a_fin_needs_slot, cmd.fin, sts.out_free, "output overwritten")
  `SFCC_ASSERT_NEXT(a_sample_starts_walk, sample_beat, cmd.issue, "walk not started")
  `SFCC_ASSERT_NOW(a_out_from_fin, $rose(out_valid_o), $past(cmd.fin), "result without finish")

endmodule
